// ----- rtl/crfd_pkg.sv -----
// shared constants, codes and types of the response frame decoder
`timescale 1ns / 1ps

package crfd_pkg;

    // frame buffering
    localparam int HEAD_BYTES    = 16;
    localparam int MAX_FRAME_LEN = 255;
    localparam int LEN_W         = $clog2(MAX_FRAME_LEN + 1);

    // queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result field widths
    localparam int FREQ_W   = 34;
    localparam int MODE_W   = 4;
    localparam int OFFSET_W = 16;
    localparam int SPEED_W  = 12;

    // framing
    localparam logic [7:0] PREAMBLE = 8'hFE;
    localparam int MIN_FRAME_LEN    = 6;

    // command codes
    localparam logic [7:0] CMD_FREQ_A    = 8'h03;
    localparam logic [7:0] CMD_MODE_A    = 8'h04;
    localparam logic [7:0] CMD_SPLIT     = 8'h0F;
    localparam logic [7:0] CMD_LEVEL     = 8'h14;
    localparam logic [7:0] CMD_PTT       = 8'h1C;
    localparam logic [7:0] CMD_OFFSET    = 8'h21;
    localparam logic [7:0] CMD_FREQ_B    = 8'h25;
    localparam logic [7:0] CMD_MODE_B    = 8'h26;
    localparam logic [7:0] CMD_VFO_DATA  = 8'h27;

    // subcommand codes
    localparam logic [7:0] SUB_SHARED    = 8'h00;
    localparam logic [7:0] SUB_RIT       = 8'h01;
    localparam logic [7:0] SUB_XIT       = 8'h02;
    localparam logic [7:0] SUB_KEYER     = 8'h0C;
    localparam logic [7:0] SUB_PTT       = 8'h00;
    localparam logic [7:0] VAL_ON        = 8'h01;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_CWR   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_RTTYR = 4'd7;
    localparam logic [MODE_W-1:0] MODE_NONE  = 4'd8;
    localparam logic [7:0] RAW_MODE_MAX   = 8'd5;
    localparam logic [7:0] RAW_MODE_CWR   = 8'd7;
    localparam logic [7:0] RAW_MODE_RTTYR = 8'd8;

    // one judged frame: its kept head and its payload length
    typedef struct packed {
        logic [HEAD_BYTES-1:0][7:0] head;
        logic [LEN_W-1:0]           n;
    } frame_rec_t;

    // full state snapshot
    typedef struct packed {
        logic [FREQ_W-1:0]          freq_a;
        logic [MODE_W-1:0]          mode_a;
        logic [FREQ_W-1:0]          freq_b;
        logic [MODE_W-1:0]          mode_b;
        logic                       split_on;
        logic                       rit_on;
        logic                       xit_on;
        logic signed [OFFSET_W-1:0] rit_offset;
        logic signed [OFFSET_W-1:0] xit_offset;
        logic [SPEED_W-1:0]         cw_speed;
        logic                       transmitting;
        logic [7:0]                 frame_command;
    } snapshot_t;

endpackage

// ----- rtl/crfd_byte_if.sv -----
// received byte channel
`timescale 1ns / 1ps

interface crfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/crfd_snap_if.sv -----
// state snapshot channel
`timescale 1ns / 1ps

interface crfd_snap_if import crfd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [FREQ_W-1:0]          freq_a;
    logic [MODE_W-1:0]          mode_a;
    logic [FREQ_W-1:0]          freq_b;
    logic [MODE_W-1:0]          mode_b;
    logic                       split_on;
    logic                       rit_on;
    logic                       xit_on;
    logic signed [OFFSET_W-1:0] rit_offset;
    logic signed [OFFSET_W-1:0] xit_offset;
    logic [SPEED_W-1:0]         cw_speed;
    logic                       transmitting;
    logic [7:0]                 frame_command;

    modport source (
        output valid, output freq_a, output mode_a, output freq_b, output mode_b,
        output split_on, output rit_on, output xit_on, output rit_offset,
        output xit_offset, output cw_speed, output transmitting, output frame_command,
        input ready
    );
    modport sink (
        input valid, input freq_a, input mode_a, input freq_b, input mode_b,
        input split_on, input rit_on, input xit_on, input rit_offset,
        input xit_offset, input cw_speed, input transmitting, input frame_command,
        output ready
    );
endinterface

// ----- rtl/crfd_front.sv -----
// frame assembly: head buffer, length count and frame check
`timescale 1ns / 1ps

module crfd_front import crfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    crfd_byte_if.sink  rx,
    input  logic       q_full,
    output logic       push,
    output frame_rec_t rec
);

    logic [LEN_W-1:0]            len_reg;
    logic [LEN_W-1:0]            len_next;
    logic [LEN_W-1:0]            len_inc;
    logic [HEAD_BYTES-1:0][7:0]  head_reg;
    logic [HEAD_BYTES-1:0][7:0]  head_cur;
    logic                        accept;
    logic                        keep;

    // a request is taken whenever the queue has room
    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    // saturating length including the current byte
    assign len_inc = (len_reg < LEN_W'(MAX_FRAME_LEN)) ? len_reg + LEN_W'(1) : len_reg;

    // head view with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < HEAD_BYTES; i++)
        begin
            head_cur[i] = (int'(len_reg) == i) ? rx.rx_byte : head_reg[i];
        end
    end

    // frame check at the last byte
    assign keep = (len_inc >= LEN_W'(MIN_FRAME_LEN))
                  && (head_cur[0] == PREAMBLE) && (head_cur[1] == PREAMBLE);
    assign push = accept && rx.frame_end && keep;

    assign rec.head = head_cur;
    assign rec.n    = len_inc - LEN_W'(MIN_FRAME_LEN);

    // length counter restarts after every frame
    always_comb
    begin
        len_next = len_reg;
        if (accept)
        begin
            len_next = rx.frame_end ? '0 : len_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // head bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg <= head_cur;
        end
    end

`ifndef SYNTHESIS
    a_len_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rx.frame_end |=> len_reg == '0)
        else $error("frame length not cleared after last byte");
    a_push_checked: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> rec.head[0] == PREAMBLE && rec.head[1] == PREAMBLE
                 && rec.n <= LEN_W'(MAX_FRAME_LEN - MIN_FRAME_LEN))
        else $error("unchecked frame queued");
`endif

endmodule

// ----- rtl/crfd_queue.sv -----
// short frame queue between the front and the back
`timescale 1ns / 1ps

module crfd_queue import crfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t wr_rec,
    output logic       full,
    output logic       q_valid,
    output frame_rec_t rd_rec,
    input  logic       pop
);

    frame_rec_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign rd_rec  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue read while empty");
`endif

endmodule

// ----- rtl/crfd_back.sv -----
// command decode, radio state update and snapshot output
`timescale 1ns / 1ps

module crfd_back import crfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  frame_rec_t  q_rec,
    output logic        pop,
    crfd_snap_if.source snap
);

    // partial sum widths: three digit pairs and two digit pairs
    localparam int FLO_W       = 21;
    localparam int FHI_W       = 15;
    localparam int MAG_W       = 15;
    localparam int SX_W        = 20;
    localparam int SPEED_SCALE = 42;
    localparam int SPEED_ROUND = 127;
    localparam int SPEED_DIV   = 255;
    localparam int SPEED_BASE  = 6;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + SPEED_DIV - 1) / SPEED_DIV;
    localparam int RECIP_W     = 21;
    localparam int PROD_W      = SX_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic [7:0]                 cmd;
        logic                       freq_a_we;
        logic                       freq_b_we;
        logic [FLO_W-1:0]           freq_lo;
        logic [FHI_W-1:0]           freq_hi;
        logic                       mode_a_we;
        logic                       mode_b_we;
        logic [MODE_W-1:0]          mode_val;
        logic                       split_we;
        logic                       split_val;
        logic                       rit_flag_we;
        logic                       xit_flag_we;
        logic                       flag_val;
        logic                       rit_off_we;
        logic                       xit_off_we;
        logic signed [OFFSET_W-1:0] off_val;
        logic                       speed_we;
        logic [SX_W-1:0]            speed_x;
        logic                       tx_we;
        logic                       tx_val;
    } upd_t;

    // payload byte i of a frame, zero beyond the kept head
    function automatic logic [7:0] pl(input frame_rec_t r, input int i);
        if (i + 5 < HEAD_BYTES)
        begin
            return r.head[i + 5];
        end
        return 8'h00;
    endfunction

    // two bcd digits to their value, nibbles taken at face value
    function automatic logic [7:0] bcd_pair(input logic [7:0] b);
        return 8'(b[3:0]) + 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0});
    endfunction

    function automatic logic [MODE_W-1:0] map_mode(input logic [7:0] c);
        logic [MODE_W-1:0] m;
        if (c <= RAW_MODE_MAX)
        begin
            m = MODE_W'(c);
        end
        else if (c == RAW_MODE_CWR)
        begin
            m = MODE_CWR;
        end
        else if (c == RAW_MODE_RTTYR)
        begin
            m = MODE_RTTYR;
        end
        else
        begin
            m = MODE_NONE;
        end
        return m;
    endfunction

    // signed offset: low byte ones and tens, high byte hundreds and thousands
    function automatic logic signed [OFFSET_W-1:0] offset_val(input logic [7:0] lo,
                                                             input logic [7:0] hi,
                                                             input logic [7:0] sgn);
        logic [MAG_W-1:0]    mag;
        logic [OFFSET_W-1:0] ext;
        mag = MAG_W'(bcd_pair(lo)) + MAG_W'(bcd_pair(hi)) * MAG_W'(100);
        ext = OFFSET_W'(mag);
        return (sgn != 8'h00) ? $signed(-ext) : $signed(ext);
    endfunction

    upd_t                       a_reg;
    upd_t                       a_next;
    logic                       a_valid_reg;
    logic                       a_load;
    logic                       fire_b;
    logic [LEN_W-1:0]           n;
    logic [7:0]                 cmd;
    logic [4:0][7:0]            fbytes;
    logic [4:0][7:0]            fpairs;
    logic [MAG_W-1:0]           level;
    logic                       ofs_flag_we;
    logic                       ofs_off_we;
    logic                       ofs_flag_val;
    logic signed [OFFSET_W-1:0] ofs_val;

    logic [FREQ_W-1:0]          freq_a_reg;
    logic [FREQ_W-1:0]          freq_a_next;
    logic [FREQ_W-1:0]          freq_b_reg;
    logic [FREQ_W-1:0]          freq_b_next;
    logic [MODE_W-1:0]          mode_a_reg;
    logic [MODE_W-1:0]          mode_a_next;
    logic [MODE_W-1:0]          mode_b_reg;
    logic [MODE_W-1:0]          mode_b_next;
    logic                       split_reg;
    logic                       split_next;
    logic                       rit_reg;
    logic                       rit_next;
    logic                       xit_reg;
    logic                       xit_next;
    logic                       tx_reg;
    logic                       tx_next;
    logic signed [OFFSET_W-1:0] rit_off_reg;
    logic signed [OFFSET_W-1:0] rit_off_next;
    logic signed [OFFSET_W-1:0] xit_off_reg;
    logic signed [OFFSET_W-1:0] xit_off_next;
    logic [SPEED_W-1:0]         speed_reg;
    logic [SPEED_W-1:0]         speed_next;
    logic [FREQ_W-1:0]          freq_new;
    logic [PROD_W-1:0]          speed_prod;
    logic [QUO_W-1:0]           speed_quo;
    logic [SPEED_W-1:0]         speed_new;
    snapshot_t                  snap_reg;
    snapshot_t                  snap_next;
    logic                       snap_valid_reg;
    logic                       snap_valid_next;

    // pipeline control
    assign fire_b = a_valid_reg && (!snap_valid_reg || snap.ready);
    assign a_load = q_valid && (!a_valid_reg || fire_b);
    assign pop    = a_load;

    assign n   = q_rec.n;
    assign cmd = q_rec.head[4];

    // frequency digit bytes: plain frequency reply or combined vfo reply
    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            fbytes[k] = (cmd == CMD_VFO_DATA) ? pl(q_rec, k + 5) : pl(q_rec, k);
            fpairs[k] = bcd_pair(fbytes[k]);
        end
    end

    assign level = MAG_W'(bcd_pair(pl(q_rec, 1))) * MAG_W'(100)
                   + MAG_W'(bcd_pair(pl(q_rec, 2)));

    // rit or xit reply: flag only, flag and offset, or offset only
    always_comb
    begin
        ofs_flag_we  = 1'b0;
        ofs_off_we   = 1'b0;
        ofs_flag_val = (pl(q_rec, 1) == VAL_ON);
        ofs_val      = offset_val(pl(q_rec, 1), pl(q_rec, 2), pl(q_rec, 4));
        if (n == LEN_W'(2))
        begin
            ofs_flag_we = 1'b1;
        end
        else if (n >= LEN_W'(5))
        begin
            ofs_off_we = 1'b1;
            if (pl(q_rec, 1) <= VAL_ON && n >= LEN_W'(6))
            begin
                ofs_flag_we = 1'b1;
                ofs_val     = offset_val(pl(q_rec, 2), pl(q_rec, 3), pl(q_rec, 5));
            end
        end
    end

    // command decode into update requests
    always_comb
    begin
        a_next             = '0;
        a_next.cmd         = cmd;
        a_next.freq_lo     = FLO_W'(fpairs[0]) + FLO_W'(fpairs[1]) * FLO_W'(100)
                             + FLO_W'(fpairs[2]) * FLO_W'(10000);
        a_next.freq_hi     = FHI_W'(fpairs[3]) + FHI_W'(fpairs[4]) * FHI_W'(100);
        a_next.mode_val    = map_mode(pl(q_rec, 0));
        a_next.split_val   = (pl(q_rec, 0) == VAL_ON);
        a_next.flag_val    = ofs_flag_val;
        a_next.off_val     = ofs_val;
        a_next.speed_x     = SX_W'(level) * SX_W'(SPEED_SCALE) + SX_W'(SPEED_ROUND);
        a_next.tx_val      = (pl(q_rec, 1) == VAL_ON);
        unique case (cmd)
            CMD_FREQ_A:
            begin
                a_next.freq_a_we = (n >= LEN_W'(5));
            end
            CMD_FREQ_B:
            begin
                a_next.freq_b_we = (n >= LEN_W'(5));
            end
            CMD_MODE_A:
            begin
                a_next.mode_a_we = (n >= LEN_W'(1));
            end
            CMD_MODE_B:
            begin
                a_next.mode_b_we = (n >= LEN_W'(1));
            end
            CMD_SPLIT:
            begin
                a_next.split_we = (n >= LEN_W'(1));
            end
            CMD_OFFSET:
            begin
                if (n >= LEN_W'(1))
                begin
                    priority if (pl(q_rec, 0) == SUB_RIT)
                    begin
                        a_next.rit_flag_we = ofs_flag_we;
                        a_next.rit_off_we  = ofs_off_we;
                    end
                    else if (pl(q_rec, 0) == SUB_XIT)
                    begin
                        a_next.xit_flag_we = ofs_flag_we;
                        a_next.xit_off_we  = ofs_off_we;
                    end
                    else if (pl(q_rec, 0) == SUB_SHARED && n >= LEN_W'(4))
                    begin
                        a_next.rit_off_we = 1'b1;
                        a_next.xit_off_we = 1'b1;
                        a_next.off_val    = offset_val(pl(q_rec, 2), pl(q_rec, 1),
                                                       pl(q_rec, 3));
                    end
                    else
                    begin
                        a_next.rit_off_we = 1'b0;
                    end
                end
            end
            CMD_LEVEL:
            begin
                a_next.speed_we = (n >= LEN_W'(3)) && (pl(q_rec, 0) == SUB_KEYER);
            end
            CMD_PTT:
            begin
                a_next.tx_we = (n >= LEN_W'(2)) && (pl(q_rec, 0) == SUB_PTT);
            end
            CMD_VFO_DATA:
            begin
                a_next.freq_a_we = (n >= LEN_W'(11));
                a_next.mode_a_we = (n >= LEN_W'(11));
                a_next.mode_val  = map_mode(pl(q_rec, 10));
            end
            default:
            begin
                a_next.freq_a_we = 1'b0;
            end
        endcase
    end

    // decode stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (fire_b)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_reg <= a_next;
        end
    end

    // final frequency sum and keyer speed scaling by reciprocal
    assign freq_new   = FREQ_W'(a_reg.freq_hi) * FREQ_W'(1000000) + FREQ_W'(a_reg.freq_lo);
    assign speed_prod = PROD_W'(a_reg.speed_x) * PROD_W'(RECIP_MUL);
    assign speed_quo  = speed_prod[PROD_W-1:RECIP_SHIFT];
    assign speed_new  = SPEED_W'(speed_quo + QUO_W'(SPEED_BASE));

    // state update
    always_comb
    begin
        freq_a_next  = (fire_b && a_reg.freq_a_we) ? freq_new : freq_a_reg;
        freq_b_next  = (fire_b && a_reg.freq_b_we) ? freq_new : freq_b_reg;
        mode_a_next  = (fire_b && a_reg.mode_a_we) ? a_reg.mode_val : mode_a_reg;
        mode_b_next  = (fire_b && a_reg.mode_b_we) ? a_reg.mode_val : mode_b_reg;
        split_next   = (fire_b && a_reg.split_we) ? a_reg.split_val : split_reg;
        rit_next     = (fire_b && a_reg.rit_flag_we) ? a_reg.flag_val : rit_reg;
        xit_next     = (fire_b && a_reg.xit_flag_we) ? a_reg.flag_val : xit_reg;
        tx_next      = (fire_b && a_reg.tx_we) ? a_reg.tx_val : tx_reg;
        rit_off_next = (fire_b && a_reg.rit_off_we) ? a_reg.off_val : rit_off_reg;
        xit_off_next = (fire_b && a_reg.xit_off_we) ? a_reg.off_val : xit_off_reg;
        speed_next   = (fire_b && a_reg.speed_we) ? speed_new : speed_reg;
    end

    // snapshot of the updated state
    always_comb
    begin
        snap_next.freq_a        = freq_a_next;
        snap_next.mode_a        = mode_a_next;
        snap_next.freq_b        = freq_b_next;
        snap_next.mode_b        = mode_b_next;
        snap_next.split_on      = split_next;
        snap_next.rit_on        = rit_next;
        snap_next.xit_on        = xit_next;
        snap_next.rit_offset    = rit_off_next;
        snap_next.xit_offset    = xit_off_next;
        snap_next.cw_speed      = speed_next;
        snap_next.transmitting  = tx_next;
        snap_next.frame_command = a_reg.cmd;
        snap_valid_next = fire_b ? 1'b1 : (snap.ready ? 1'b0 : snap_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_a_reg     <= '0;
            freq_b_reg     <= '0;
            mode_a_reg     <= MODE_NONE;
            mode_b_reg     <= MODE_NONE;
            split_reg      <= 1'b0;
            rit_reg        <= 1'b0;
            xit_reg        <= 1'b0;
            tx_reg         <= 1'b0;
            rit_off_reg    <= '0;
            xit_off_reg    <= '0;
            speed_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            freq_a_reg     <= freq_a_next;
            freq_b_reg     <= freq_b_next;
            mode_a_reg     <= mode_a_next;
            mode_b_reg     <= mode_b_next;
            split_reg      <= split_next;
            rit_reg        <= rit_next;
            xit_reg        <= xit_next;
            tx_reg         <= tx_next;
            rit_off_reg    <= rit_off_next;
            xit_off_reg    <= xit_off_next;
            speed_reg      <= speed_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_b)
        begin
            snap_reg <= snap_next;
        end
    end

    // output channel
    assign snap.valid         = snap_valid_reg;
    assign snap.freq_a        = snap_reg.freq_a;
    assign snap.mode_a        = snap_reg.mode_a;
    assign snap.freq_b        = snap_reg.freq_b;
    assign snap.mode_b        = snap_reg.mode_b;
    assign snap.split_on      = snap_reg.split_on;
    assign snap.rit_on        = snap_reg.rit_on;
    assign snap.xit_on        = snap_reg.xit_on;
    assign snap.rit_offset    = snap_reg.rit_offset;
    assign snap.xit_offset    = snap_reg.xit_offset;
    assign snap.cw_speed      = snap_reg.cw_speed;
    assign snap.transmitting  = snap_reg.transmitting;
    assign snap.frame_command = snap_reg.frame_command;

`ifndef SYNTHESIS
    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !fire_b |=> a_valid_reg)
        else $error("decoded frame lost while stalled");
    a_snap_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        fire_b |=> snap.valid && snap.frame_command == $past(a_reg.cmd))
        else $error("snapshot does not follow decoded frame");
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_a_reg <= MODE_NONE && mode_b_reg <= MODE_NONE)
        else $error("mode register out of range");
`endif

endmodule

// ----- rtl/civ_response_frame_decoder_unit.sv -----
// top level of the transceiver response frame decoder
// a good frame passes the queue, then the decode stage and snapshot registers
// rates: one byte per cycle while the queue has room, one snapshot per cycle at most
// a frame queue of two entries decouples byte intake from decode and output stall
// reset: asynchronous, restores the radio state to its cleared values at once
// the head buffer is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module civ_response_frame_decoder_unit import crfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    crfd_byte_if.sink   rx,
    crfd_snap_if.source snap
);

    logic       push;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    frame_rec_t wr_rec;
    frame_rec_t rd_rec;

    // byte intake and frame check
    crfd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_full (q_full),
        .push   (push),
        .rec    (wr_rec)
    );

    // judged frames awaiting decode
    crfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_rec  (wr_rec),
        .full    (q_full),
        .q_valid (q_valid),
        .rd_rec  (rd_rec),
        .pop     (pop)
    );

    // decode, state update and snapshot
    crfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_rec   (rd_rec),
        .pop     (pop),
        .snap    (snap)
    );

endmodule
